[rtl/asc_pkg.sv]
// Shared types and constants for the ADC supply and temperature calibration core.
// Used by asc_div and by the top level; no dependencies.
`default_nettype none

package asc_pkg;

  localparam int unsigned KIND_W     = 3;
  localparam int unsigned CODE_W     = 12;
  localparam int unsigned TEMP_W     = 9;
  localparam int unsigned SCALER_W   = 4;
  localparam int unsigned SUPPLY_W   = 16;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam int unsigned MUL_A_W    = 23;
  localparam int unsigned MUL_B_W    = 17;
  localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W      = PROD_W + 1;
  localparam int unsigned DVD_W      = PROD_W;
  localparam int unsigned DVS_W      = CODE_W;

  localparam int unsigned VDDA_RESET_MV_DEF = 3300;

  localparam logic [CODE_W-1:0]   ADC_FULL_SCALE = 12'd4095;
  localparam logic [SUPPLY_W-1:0] SUPPLY_MAX     = 16'hFFFF;

  typedef enum logic [KIND_W-1:0] {
    REQ_SET_SUPPLY  = 3'd0,
    REQ_READ_SUPPLY = 3'd1,
    REQ_CHANNEL_MV  = 3'd2,
    REQ_BATTERY_MV  = 3'd3,
    REQ_TEMPERATURE = 3'd4
  } req_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VREFINT_CAL  = 3'd0,
    REG_CAL_SUPPLY   = 3'd1,
    REG_TS_CODE_LOW  = 3'd2,
    REG_TS_CODE_HIGH = 3'd3,
    REG_TS_TEMP_LOW  = 3'd4,
    REG_TS_TEMP_HIGH = 3'd5,
    REG_VBAT_SCALER  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

[rtl/adc_supply_and_temperature_calibration_core.sv]
// Top level: configuration registers, supply store, sequencer and shared datapath.
// Depends on asc_pkg and asc_div.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries req_type_i and sample_code_i.
//   A transaction is taken at a clock edge with valid high and stall low.
//   Output channel (out_valid_o / out_stall_i) returns value_o and error_o,
//   exactly one result transaction per input transaction, in order.
//   Configuration writes (cfg_valid_i / cfg_ready_o) are always taken and
//   should only be issued while the core is idle.
// Timing:
//   One item at a time; in_stall_o stays high until the result is in the
//   output register. The 40-step restoring divider is used at most once
//   per item and at most twice for temperature, behind a single shared
//   23x17 multiplier.
// Reset:
//   Registers return to their factory values, the supply store to
//   VDDA_RESET_MV. A stalled result holds in the output register; the core
//   waits before loading a new one.
`default_nettype none

module adc_supply_and_temperature_calibration_core #(
  parameter int unsigned VDDA_RESET_MV = asc_pkg::VDDA_RESET_MV_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [asc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [asc_pkg::CODE_W-1:0]         cfg_data_i,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire  [asc_pkg::KIND_W-1:0]         req_type_i,
  input  wire  [asc_pkg::CODE_W-1:0]         sample_code_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic signed [asc_pkg::VALUE_W-1:0] value_o,
  output logic                               error_o
);
  import asc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_M0, S_M1, S_D0, S_W0, S_M2, S_D1, S_W1, S_POST, S_OUT
  } state_e;

  logic [CODE_W-1:0]   vref_q, cal_q, tcl_q, tch_q;
  logic [TEMP_W-1:0]   tlo_q, thi_q;
  logic [SCALER_W-1:0] scaler_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vref_q   <= 12'd1655;
      cal_q    <= 12'd3000;
      tcl_q    <= 12'd1034;
      tch_q    <= 12'd1375;
      tlo_q    <= 9'd30;
      thi_q    <= 9'd130;
      scaler_q <= 4'd3;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_VREFINT_CAL:  vref_q   <= cfg_data_i;
        REG_CAL_SUPPLY:   cal_q    <= cfg_data_i;
        REG_TS_CODE_LOW:  tcl_q    <= cfg_data_i;
        REG_TS_CODE_HIGH: tch_q    <= cfg_data_i;
        REG_TS_TEMP_LOW:  tlo_q    <= cfg_data_i[TEMP_W-1:0];
        REG_TS_TEMP_HIGH: thi_q    <= cfg_data_i[TEMP_W-1:0];
        REG_VBAT_SCALER:  scaler_q <= cfg_data_i[SCALER_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  state_e                    state_q;
  req_kind_e                 kind_q;
  logic [CODE_W-1:0]         code_q;
  logic                      neg_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic [SUPPLY_W-1:0]       supply_q;
  logic [VALUE_W-1:0]        res_value_q;
  logic                      res_err_q;
  logic                      out_valid_q;
  logic [VALUE_W-1:0]        out_value_q;
  logic                      out_err_q;

  logic signed [TEMP_W:0]    tlo_s, thi_s, tdiff_s;
  logic signed [CODE_W:0]    cdiff_s;
  logic [CODE_W-1:0]         cdiff_abs;
  logic [DVD_W-1:0]          acc_abs;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic                      div_start;
  logic [DVS_W-1:0]          div_divisor;
  logic [DVD_W-1:0]          div_quo;
  div_status_t               div_st;
  logic signed [ACC_W-1:0]   quo_s;
  logic                      acc_ovf;
  logic                      out_load;

  assign tlo_s     = {tlo_q[TEMP_W-1], tlo_q};
  assign thi_s     = {thi_q[TEMP_W-1], thi_q};
  assign tdiff_s   = thi_s - tlo_s;
  assign cdiff_s   = {1'b0, tch_q} - {1'b0, tcl_q};
  assign cdiff_abs = cdiff_s[CODE_W] ? CODE_W'(-cdiff_s) : cdiff_s[CODE_W-1:0];
  assign acc_abs   = acc_q[ACC_W-1] ? DVD_W'(-acc_q) : acc_q[DVD_W-1:0];
  assign quo_s     = neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign acc_ovf   = ~((&acc_q[ACC_W-1:VALUE_W-1]) | ~(|acc_q[ACC_W-1:VALUE_W-1]));
  assign out_load  = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_M0: begin
        case (kind_q)
          REQ_SET_SUPPLY: begin
            mul_a = {{(MUL_A_W-CODE_W){1'b0}}, vref_q};
            mul_b = {{(MUL_B_W-CODE_W){1'b0}}, cal_q};
          end
          REQ_CHANNEL_MV: begin
            mul_a = {{(MUL_A_W-CODE_W){1'b0}}, code_q};
            mul_b = {1'b0, supply_q};
          end
          REQ_BATTERY_MV: begin
            mul_a = {{(MUL_A_W-SCALER_W){1'b0}}, scaler_q};
            mul_b = {{(MUL_B_W-CODE_W){1'b0}}, code_q};
          end
          default: begin
            mul_a = MUL_A_W'(tdiff_s);
            mul_b = {{(MUL_B_W-CODE_W){1'b0}}, code_q};
          end
        endcase
      end
      S_M1: begin
        mul_a = acc_q[MUL_A_W-1:0];
        mul_b = {1'b0, supply_q};
      end
      S_M2: begin
        mul_a = MUL_A_W'(tdiff_s);
        mul_b = {{(MUL_B_W-CODE_W){1'b0}}, tcl_q};
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    div_start   = 1'b0;
    div_divisor = ADC_FULL_SCALE;
    if (state_q == S_D0) begin
      div_start = 1'b1;
      case (kind_q)
        REQ_SET_SUPPLY:  div_divisor = code_q;
        REQ_TEMPERATURE: div_divisor = cal_q;
        default:         div_divisor = ADC_FULL_SCALE;
      endcase
    end else if (state_q == S_D1) begin
      div_start   = 1'b1;
      div_divisor = cdiff_abs;
    end
  end

  asc_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_abs),
    .divisor_i  (div_divisor),
    .status_o   (div_st),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= REQ_SET_SUPPLY;
      code_q      <= '0;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      supply_q    <= SUPPLY_W'(VDDA_RESET_MV);
      res_value_q <= '0;
      res_err_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_err_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q <= req_kind_e'(req_type_i);
            code_q <= sample_code_i;
            case (req_type_i) inside
              REQ_SET_SUPPLY: begin
                if (sample_code_i == '0) begin
                  // force the saturation path
                  acc_q   <= {{(ACC_W-SUPPLY_W-1){1'b0}}, 1'b1, {SUPPLY_W{1'b0}}};
                  state_q <= S_POST;
                end else begin
                  state_q <= S_M0;
                end
              end
              REQ_READ_SUPPLY: begin
                res_value_q <= {{(VALUE_W-SUPPLY_W){1'b0}}, supply_q};
                res_err_q   <= 1'b0;
                state_q     <= S_OUT;
              end
              REQ_CHANNEL_MV, REQ_BATTERY_MV: state_q <= S_M0;
              REQ_TEMPERATURE: begin
                if (cdiff_s == '0 || cal_q == '0) begin
                  res_value_q <= '0;
                  res_err_q   <= 1'b1;
                  state_q     <= S_OUT;
                end else begin
                  state_q <= S_M0;
                end
              end
              default: begin
                res_value_q <= '0;
                res_err_q   <= 1'b1;
                state_q     <= S_OUT;
              end
            endcase
          end
        end
        S_M0: begin
          acc_q <= ACC_W'(prod);
          if (kind_q == REQ_BATTERY_MV || kind_q == REQ_TEMPERATURE) begin
            state_q <= S_M1;
          end else begin
            state_q <= S_D0;
          end
        end
        S_M1: begin
          acc_q   <= ACC_W'(prod);
          state_q <= S_D0;
        end
        S_D0: begin
          neg_q   <= acc_q[ACC_W-1];
          state_q <= S_W0;
        end
        S_W0: begin
          if (div_st.done) begin
            acc_q   <= quo_s;
            state_q <= (kind_q == REQ_TEMPERATURE) ? S_M2 : S_POST;
          end
        end
        S_M2: begin
          acc_q   <= acc_q - ACC_W'(prod);
          state_q <= S_D1;
        end
        S_D1: begin
          neg_q   <= acc_q[ACC_W-1] ^ cdiff_s[CODE_W];
          state_q <= S_W1;
        end
        S_W1: begin
          if (div_st.done) begin
            acc_q   <= quo_s + ACC_W'(tlo_s);
            state_q <= S_POST;
          end
        end
        S_POST: begin
          if (kind_q == REQ_SET_SUPPLY) begin
            if (|acc_q[ACC_W-1:SUPPLY_W]) begin
              supply_q    <= SUPPLY_MAX;
              res_value_q <= {{(VALUE_W-SUPPLY_W){1'b0}}, SUPPLY_MAX};
              res_err_q   <= 1'b1;
            end else begin
              supply_q    <= acc_q[SUPPLY_W-1:0];
              res_value_q <= {{(VALUE_W-SUPPLY_W){1'b0}}, acc_q[SUPPLY_W-1:0]};
              res_err_q   <= 1'b0;
            end
          end else if (acc_ovf) begin
            res_value_q <= acc_q[ACC_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                          : {1'b0, {(VALUE_W-1){1'b1}}};
            res_err_q   <= 1'b1;
          end else begin
            res_value_q <= acc_q[VALUE_W-1:0];
            res_err_q   <= 1'b0;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_value_q <= res_value_q;
            out_err_q   <= res_err_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign error_o     = out_err_q;

  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_st.busy || div_st.done) |-> (state_q == S_W0 || state_q == S_W1))
    else $error("divider active outside a wait state");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("accepted transaction did not start work");

  a_supply_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(supply_q) |-> ($past(state_q) == S_POST && $past(kind_q) == REQ_SET_SUPPLY))
    else $error("supply store changed outside a reference update");

endmodule

`default_nettype wire

[rtl/asc_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on asc_pkg for the status struct and the default widths.
`default_nettype none

module asc_div #(
  parameter int unsigned DVD_W = asc_pkg::DVD_W,
  parameter int unsigned DVS_W = asc_pkg::DVS_W
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start_i,
  input  wire  [DVD_W-1:0]         dividend_i,
  input  wire  [DVS_W-1:0]         divisor_i,
  output asc_pkg::div_status_t     status_o,
  output logic [DVD_W-1:0]         quotient_o
);
  import asc_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = ~diff[DVS_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
        quo_q  <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        quo_q <= {quo_q[DVD_W-2:0], fits};
        rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;

endmodule

`default_nettype wire
